FILE: sv/stc_pkg.sv
`timescale 1ns / 1ps
package stc_pkg;

  localparam int VAL_W   = 30;
  localparam int NODE_W  = 5;
  localparam int COUNT_W = 6;
  localparam int EXP_BITS_W = 5;

  localparam logic [VAL_W-1:0] MOD_P = 30'd998244353;
  localparam logic [VAL_W-1:0] EXP_E = MOD_P - 30'd2;
  localparam logic [EXP_BITS_W-1:0] EXP_LAST = 5'd29;

  // request and response of the shared modular multiplier
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [VAL_W-1:0] res;
  } mm_rsp_t;

endpackage

FILE: sv/stc_if.sv
`timescale 1ns / 1ps
interface stc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [stc_pkg::NODE_W-1:0] node_u;
  logic [stc_pkg::NODE_W-1:0] node_v;
  modport source (output valid, kind, node_u, node_v, input ready);
  modport sink (input valid, kind, node_u, node_v, output ready);
endinterface

interface stc_out_if;
  logic                      valid;
  logic                      ready;
  logic [stc_pkg::VAL_W-1:0] tree_count;
  logic                      edge_dropped;
  modport source (output valid, tree_count, edge_dropped, input ready);
  modport sink (input valid, tree_count, edge_dropped, output ready);
endinterface

FILE: sv/spanning_tree_count_mod_prime_top.sv
`timescale 1ns / 1ps
// Edge word: a dropped edge or self-loop writes nothing; else up to 4 entries are updated.
// Count word: elimination over an m = node_count-1 square; each modular multiply runs in
// the bit-serial multiplier, for each of the about m^3/3 entry updates and, per column,
// for the pivot and its Fermat inverse.
// Reset and every count start a clearing pass over all 2^(2*clog2(MAX_NODES)) entries (1024 at
// 32 nodes) in which no word is accepted; node_count resets to 0.
module spanning_tree_count_mod_prime_top #(
  parameter int MAX_NODES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  stc_in_if.sink                      in_ch,
  stc_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [stc_pkg::COUNT_W-1:0] cfg_wdata
);

  localparam int IW    = $clog2(MAX_NODES);
  localparam int AW    = 2 * IW;
  localparam int EW    = $clog2(MAX_NODES + 1);
  localparam int CMP_W = 10;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_EDGE_RD, S_EDGE_WR, S_PIV_RD, S_PIV_CHK,
    S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB, S_DIAG_RD, S_DIAG_MUL, S_DIAG_SET,
    S_INV_RES, S_INV_RES_SET, S_INV_BASE, S_INV_BASE_SET,
    S_ROW_RD, S_ROW_MUL, S_ROW_SET, S_K_RD, S_K_MUL, S_K_RD2, S_K_WR,
    S_NEXT_COL, S_MUL_WAIT, S_EMIT
  } state_t;

  state_t                         state_r;
  state_t                         ret_r;
  logic [stc_pkg::COUNT_W-1:0]    node_count_r;
  logic [EW-1:0]                  eff_n;
  logic [CMP_W-1:0]               eff_ext;
  logic [CMP_W-1:0]               u_ext;
  logic [CMP_W-1:0]               v_ext;
  logic                           u_out;
  logic                           v_out;
  logic                           u_in;
  logic                           v_in;
  logic [IW-1:0]                  eu_r;
  logic [IW-1:0]                  ev_r;
  logic [3:0]                     een_r;
  logic [1:0]                     op_r;
  logic                           dropped_r;
  logic [stc_pkg::VAL_W-1:0]      det_r;
  logic [IW-1:0]                  m_r;
  logic [IW-1:0]                  last;
  logic [IW-1:0]                  col_r;
  logic [IW-1:0]                  r_r;
  logic [IW-1:0]                  piv_r;
  logic [IW-1:0]                  k_r;
  logic [stc_pkg::VAL_W-1:0]      tmp_r;
  logic [stc_pkg::VAL_W-1:0]      pv_r;
  logic [stc_pkg::VAL_W-1:0]      inv_r;
  logic [stc_pkg::VAL_W-1:0]      base_r;
  logic [stc_pkg::VAL_W-1:0]      f_r;
  logic [stc_pkg::VAL_W-1:0]      sub_r;
  logic [stc_pkg::EXP_BITS_W-1:0] bit_r;
  logic [AW-1:0]                  clr_r;
  logic                           out_valid_r;
  logic [stc_pkg::VAL_W-1:0]      out_tc_r;
  logic                           out_dr_r;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [stc_pkg::VAL_W-1:0]      ram_wdata;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic [stc_pkg::VAL_W-1:0]      ram_rdata;
  logic [AW-1:0]                  edge_addr;
  logic [stc_pkg::VAL_W-1:0]      edge_inc;
  logic [stc_pkg::VAL_W-1:0]      edge_dec;
  logic [stc_pkg::VAL_W-1:0]      k_diff;
  stc_pkg::mm_req_t               mm_req;
  stc_pkg::mm_rsp_t               mm_rsp;
  logic                           accept;

  stc_ram #(.WIDTH(stc_pkg::VAL_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stc_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  // clamp node count and range-check the endpoints
  always_comb begin
    if (32'(node_count_r) > MAX_NODES) begin
      eff_n = EW'(MAX_NODES);
    end else begin
      eff_n = EW'(node_count_r);
    end
    eff_ext = CMP_W'(eff_n);
    u_ext   = CMP_W'(in_ch.node_u);
    v_ext   = CMP_W'(in_ch.node_v);
    u_out   = u_ext >= eff_ext;
    v_out   = v_ext >= eff_ext;
    u_in    = (u_ext + 1'b1) < eff_ext;
    v_in    = (v_ext + 1'b1) < eff_ext;
  end

  assign last   = m_r - 1'b1;
  assign accept = in_ch.valid && in_ch.ready;

  // entry address of the current edge update
  always_comb begin
    case (op_r)
      2'd0:    edge_addr = {eu_r, eu_r};
      2'd1:    edge_addr = {ev_r, ev_r};
      2'd2:    edge_addr = {eu_r, ev_r};
      default: edge_addr = {ev_r, eu_r};
    endcase
    edge_inc = (ram_rdata == stc_pkg::MOD_P - 1'b1) ? '0 : ram_rdata + 1'b1;
    edge_dec = (ram_rdata == '0) ? stc_pkg::MOD_P - 1'b1 : ram_rdata - 1'b1;
    if (ram_rdata >= sub_r) begin
      k_diff = ram_rdata - sub_r;
    end else begin
      k_diff = ram_rdata + (stc_pkg::MOD_P - sub_r);
    end
  end

  // memory and multiplier requests per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    mm_req    = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      S_EDGE_RD: begin
        ram_re    = een_r[op_r];
        ram_raddr = edge_addr;
      end
      S_EDGE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = edge_addr;
        ram_wdata = op_r[1] ? edge_dec : edge_inc;
      end
      S_PIV_RD: begin
        ram_re    = 1'b1;
        ram_raddr = {r_r, col_r};
      end
      S_SW_RA: begin
        ram_re    = 1'b1;
        ram_raddr = {piv_r, k_r};
      end
      S_SW_RB: begin
        ram_re    = 1'b1;
        ram_raddr = {col_r, k_r};
      end
      S_SW_WA: begin
        ram_we    = 1'b1;
        ram_waddr = {piv_r, k_r};
        ram_wdata = ram_rdata;
      end
      S_SW_WB: begin
        ram_we    = 1'b1;
        ram_waddr = {col_r, k_r};
        ram_wdata = tmp_r;
      end
      S_DIAG_RD: begin
        ram_re    = 1'b1;
        ram_raddr = {col_r, col_r};
      end
      S_DIAG_MUL: begin
        mm_req.start = 1'b1;
        mm_req.a     = det_r;
        mm_req.b     = ram_rdata;
      end
      S_INV_RES: begin
        mm_req.start = stc_pkg::EXP_E[bit_r];
        mm_req.a     = inv_r;
        mm_req.b     = base_r;
      end
      S_INV_BASE: begin
        mm_req.start = 1'b1;
        mm_req.a     = base_r;
        mm_req.b     = base_r;
      end
      S_ROW_RD: begin
        ram_re    = 1'b1;
        ram_raddr = {r_r, col_r};
      end
      S_ROW_MUL: begin
        mm_req.start = 1'b1;
        mm_req.a     = ram_rdata;
        mm_req.b     = inv_r;
      end
      S_K_RD: begin
        ram_re    = 1'b1;
        ram_raddr = {col_r, k_r};
      end
      S_K_MUL: begin
        mm_req.start = 1'b1;
        mm_req.a     = f_r;
        mm_req.b     = ram_rdata;
      end
      S_K_RD2: begin
        ram_re    = 1'b1;
        ram_raddr = {r_r, k_r};
      end
      S_K_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {r_r, k_r};
        ram_wdata = k_diff;
      end
      default: begin
      end
    endcase
  end

  // sequencer: edge updates, elimination, result and clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      ret_r        <= S_IDLE;
      clr_r        <= '0;
      node_count_r <= '0;
      dropped_r    <= 1'b0;
      det_r        <= 30'd1;
      out_valid_r  <= 1'b0;
      op_r         <= '0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      // drop the result word once taken, unless a new one is loaded below
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          dropped_r <= 1'b0;
          det_r     <= 30'd1;
          clr_r     <= clr_r + 1'b1;
          if (clr_r == {AW{1'b1}}) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (!in_ch.kind) begin
              if (u_out || v_out) begin
                dropped_r <= 1'b1;
              end else if (in_ch.node_u != in_ch.node_v) begin
                eu_r    <= IW'(in_ch.node_u);
                ev_r    <= IW'(in_ch.node_v);
                een_r   <= {u_in && v_in, u_in && v_in, v_in, u_in};
                op_r    <= '0;
                state_r <= S_EDGE_RD;
              end
            end else if (eff_n == '0) begin
              det_r   <= '0;
              state_r <= S_EMIT;
            end else if (eff_n == EW'(1)) begin
              det_r   <= 30'd1;
              state_r <= S_EMIT;
            end else begin
              m_r     <= IW'(eff_n - 1'b1);
              det_r   <= 30'd1;
              col_r   <= '0;
              r_r     <= '0;
              state_r <= S_PIV_RD;
            end
          end
        end
        S_EDGE_RD: begin
          if (een_r[op_r]) begin
            state_r <= S_EDGE_WR;
          end else if (op_r == 2'd3) begin
            state_r <= S_IDLE;
          end else begin
            op_r <= op_r + 1'b1;
          end
        end
        S_EDGE_WR: begin
          op_r    <= op_r + 1'b1;
          state_r <= (op_r == 2'd3) ? S_IDLE : S_EDGE_RD;
        end
        S_PIV_RD: state_r <= S_PIV_CHK;
        S_PIV_CHK: begin
          if (ram_rdata != '0) begin
            piv_r <= r_r;
            k_r   <= '0;
            state_r <= (r_r != col_r) ? S_SW_RA : S_DIAG_RD;
          end else if (r_r == last) begin
            det_r   <= '0;
            state_r <= S_EMIT;
          end else begin
            r_r     <= r_r + 1'b1;
            state_r <= S_PIV_RD;
          end
        end
        S_SW_RA: state_r <= S_SW_RB;
        S_SW_RB: begin
          tmp_r   <= ram_rdata;
          state_r <= S_SW_WA;
        end
        S_SW_WA: state_r <= S_SW_WB;
        S_SW_WB: begin
          if (k_r == last) begin
            det_r   <= (det_r == '0) ? '0 : stc_pkg::MOD_P - det_r;
            state_r <= S_DIAG_RD;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SW_RA;
          end
        end
        S_DIAG_RD: state_r <= S_DIAG_MUL;
        S_DIAG_MUL: begin
          pv_r    <= ram_rdata;
          ret_r   <= S_DIAG_SET;
          state_r <= S_MUL_WAIT;
        end
        S_DIAG_SET: begin
          det_r   <= mm_rsp.res;
          inv_r   <= 30'd1;
          base_r  <= pv_r;
          bit_r   <= '0;
          state_r <= S_INV_RES;
        end
        S_INV_RES: begin
          if (stc_pkg::EXP_E[bit_r]) begin
            ret_r   <= S_INV_RES_SET;
            state_r <= S_MUL_WAIT;
          end else begin
            state_r <= S_INV_BASE;
          end
        end
        S_INV_RES_SET: begin
          inv_r   <= mm_rsp.res;
          state_r <= S_INV_BASE;
        end
        S_INV_BASE: begin
          ret_r   <= S_INV_BASE_SET;
          state_r <= S_MUL_WAIT;
        end
        S_INV_BASE_SET: begin
          base_r <= mm_rsp.res;
          if (bit_r != stc_pkg::EXP_LAST) begin
            bit_r   <= bit_r + 1'b1;
            state_r <= S_INV_RES;
          end else if (col_r == last) begin
            state_r <= S_EMIT;
          end else begin
            r_r     <= col_r + 1'b1;
            state_r <= S_ROW_RD;
          end
        end
        S_ROW_RD: state_r <= S_ROW_MUL;
        S_ROW_MUL: begin
          ret_r   <= S_ROW_SET;
          state_r <= S_MUL_WAIT;
        end
        S_ROW_SET: begin
          f_r <= mm_rsp.res;
          if (mm_rsp.res != '0) begin
            k_r     <= col_r;
            state_r <= S_K_RD;
          end else if (r_r == last) begin
            state_r <= S_NEXT_COL;
          end else begin
            r_r     <= r_r + 1'b1;
            state_r <= S_ROW_RD;
          end
        end
        S_K_RD: state_r <= S_K_MUL;
        S_K_MUL: begin
          ret_r   <= S_K_RD2;
          state_r <= S_MUL_WAIT;
        end
        S_K_RD2: begin
          sub_r   <= mm_rsp.res;
          state_r <= S_K_WR;
        end
        S_K_WR: begin
          if (k_r != last) begin
            k_r     <= k_r + 1'b1;
            state_r <= S_K_RD;
          end else if (r_r == last) begin
            state_r <= S_NEXT_COL;
          end else begin
            r_r     <= r_r + 1'b1;
            state_r <= S_ROW_RD;
          end
        end
        S_NEXT_COL: begin
          if (col_r == last) begin
            state_r <= S_EMIT;
          end else begin
            col_r   <= col_r + 1'b1;
            r_r     <= col_r + 1'b1;
            state_r <= S_PIV_RD;
          end
        end
        S_MUL_WAIT: begin
          if (mm_rsp.done) begin
            state_r <= ret_r;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_tc_r    <= det_r;
            out_dr_r    <= dropped_r;
            clr_r       <= '0;
            state_r     <= S_CLEAR;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.tree_count   = out_tc_r;
  assign out_ch.edge_dropped = out_dr_r;

  // no word is taken while the store is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ch.ready)
    else $error("word accepted during clearing pass");

  // multiplier is never restarted while busy
  a_mul_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mm_req.start |-> !mm_rsp.busy)
    else $error("multiplier started while busy");

  // multiplier results stay reduced
  a_mul_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> mm_rsp.res < stc_pkg::MOD_P)
    else $error("multiplier result not reduced");

  // a loaded count is reduced and then the clearing pass runs
  a_emit_then_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_valid_r || out_ch.ready)) |=>
      (state_r == S_CLEAR && out_tc_r < stc_pkg::MOD_P))
    else $error("count not followed by clearing pass");

endmodule

FILE: sv/stc_ram.sv
`timescale 1ns / 1ps
module stc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/stc_mulmod.sv
`timescale 1ns / 1ps
module stc_mulmod (
  input  logic             clk,
  input  logic             rst_n,
  input  stc_pkg::mm_req_t req,
  output stc_pkg::mm_rsp_t rsp
);

  logic [stc_pkg::VAL_W-1:0]      a_r;
  logic [stc_pkg::VAL_W-1:0]      b_r;
  logic [stc_pkg::VAL_W-1:0]      acc_r;
  logic [stc_pkg::EXP_BITS_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [stc_pkg::VAL_W+1:0]      sum;
  logic [stc_pkg::VAL_W+1:0]      red1;
  logic [stc_pkg::VAL_W-1:0]      acc_nxt;

  // double, add the multiplicand on a set bit, fold back below the modulus
  always_comb begin
    sum = {1'b0, acc_r, 1'b0} + (b_r[stc_pkg::VAL_W-1] ? {2'b00, a_r} : '0);
    if (sum >= {1'b0, stc_pkg::MOD_P, 1'b0}) begin
      red1 = sum - {1'b0, stc_pkg::MOD_P, 1'b0};
    end else begin
      red1 = sum;
    end
    if (red1 >= {2'b00, stc_pkg::MOD_P}) begin
      acc_nxt = stc_pkg::VAL_W'(red1 - {2'b00, stc_pkg::MOD_P});
    end else begin
      acc_nxt = stc_pkg::VAL_W'(red1);
    end
  end

  // one multiplier bit per cycle, most significant first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        a_r    <= req.a;
        b_r    <= req.b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        b_r   <= {b_r[stc_pkg::VAL_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == stc_pkg::EXP_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule
